### src/rtdos_pkg.sv
package rtdos_pkg;

  // Fixed widths of the block.
  localparam int SUM_BITS      = 40;
  localparam int RES_BITS      = 25;
  localparam int DIV_BITS      = 16;
  localparam int REF_BITS      = 24;
  localparam int WIRE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Filter coefficient alpha = 0.6 in Q0.16 and the rounding half.
  localparam int                    ALPHA_BITS     = 16;
  localparam int                    ALPHA_IDX_BITS = $clog2(ALPHA_BITS);
  localparam logic [ALPHA_BITS-1:0] ALPHA_Q16      = 16'd39322;
  localparam logic [ALPHA_BITS-1:0] EMA_ROUND      = 16'h8000;

  // A gain of 1/8 for three- and four-wire sensors is a further right shift by three.
  localparam int GAIN_SHIFT    = 3;
  localparam int REF_IDX_BITS  = $clog2(REF_BITS);

  // Sequencer step counter.
  localparam int                  CNT_BITS = 6;
  localparam logic [CNT_BITS-1:0] EMA_LAST = CNT_BITS'(ALPHA_BITS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(SUM_BITS - 1);
  localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(REF_BITS - 1);

  // Wire type codes.
  localparam logic [WIRE_BITS-1:0] WIRE_TWO   = 2'd0;
  localparam logic [WIRE_BITS-1:0] WIRE_THREE = 2'd1;
  localparam logic [WIRE_BITS-1:0] WIRE_FOUR  = 2'd2;

  // Register reset values.
  localparam logic [DIV_BITS-1:0]  DIVISOR_RST = 16'd64;
  localparam logic [REF_BITS-1:0]  REF_RST     = 24'd4000000;
  localparam logic [WIRE_BITS-1:0] WIRE_RST    = WIRE_FOUR;
  localparam logic                 EMA_EN_RST  = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_DIVISOR = 2'd0,
    CFG_REFERENCE_MOHM = 2'd1,
    CFG_WIRE_TYPE      = 2'd2,
    CFG_EMA_ENABLE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIV_BITS-1:0]  window_divisor;
    logic [REF_BITS-1:0]  reference_mohm;
    logic [WIRE_BITS-1:0] wire_type;
    logic                 ema_enable;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMA,
    ST_EMA_WB,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_AVG,
    ST_MUL,
    ST_RES,
    ST_EMIT
  } state_t;

  typedef struct packed {
    state_t              state;
    logic [CNT_BITS-1:0] cnt;
    logic                emit;
  } ctl_t;

  typedef struct packed {
    logic ema_direct;
    logic win_end;
  } sts_t;

endpackage

### src/rtdos_seq.sv
module rtdos_seq
  import rtdos_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic out_free,
  input  sts_t sts,
  output logic in_stall,
  output ctl_t ctl
);

  state_t              state;
  state_t              state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_next;
  logic                emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_next   = '0;
        state_next = sts.ema_direct ? ST_SUM : ST_EMA;
      end
      ST_EMA: begin
        if (cnt == EMA_LAST) begin
          state_next = ST_EMA_WB;
        end else begin
          cnt_next = cnt + CNT_BITS'(1);
        end
      end
      ST_EMA_WB: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = sts.win_end ? ST_ABS : ST_IDLE;
      end
      ST_ABS: begin
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_AVG;
        end else begin
          cnt_next = cnt + CNT_BITS'(1);
        end
      end
      ST_AVG: begin
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == MUL_LAST) begin
          state_next = ST_RES;
        end else begin
          cnt_next = cnt + CNT_BITS'(1);
        end
      end
      ST_RES: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign ctl.state = state;
  assign ctl.cnt   = cnt;
  assign ctl.emit  = emit;

endmodule

### src/rtdos_dp.sv
module rtdos_dp
  import rtdos_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  ctl_t                                            ctl,
  input  cfg_t                                            cfg,
  input  logic                                            load,
  input  logic signed [SAMPLE_BITS-1:0]                   sample,
  input  logic                                            window_end,
  output sts_t                                            sts,
  output logic signed [RES_BITS-1:0]                      resistance_mohm,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]     average_q8
);

  localparam int VAL_BITS = SAMPLE_BITS + FRACTION_BITS;
  // One adder serves every step; it is wide enough for the product.
  localparam int AW       = VAL_BITS + REF_BITS + 1;
  localparam int SH_LOW   = VAL_BITS - 1;
  localparam int SH_HIGH  = VAL_BITS - 1 + GAIN_SHIFT;

  localparam logic signed [AW-1:0] VAL_MAX_W =
    {{(AW - VAL_BITS + 1){1'b0}}, {(VAL_BITS - 1){1'b1}}};
  localparam logic signed [AW-1:0] VAL_MIN_W =
    {{(AW - VAL_BITS + 1){1'b1}}, {(VAL_BITS - 1){1'b0}}};
  localparam logic [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS - 1){1'b1}}};
  localparam logic [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS - 1){1'b0}}};
  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS - 1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS - 1){1'b0}}};
  localparam logic [RES_BITS-1:0] RES_MAX = {1'b0, {(RES_BITS - 1){1'b1}}};
  localparam logic [RES_BITS-1:0] RES_MIN = {1'b1, {(RES_BITS - 1){1'b0}}};

  // Architectural state.
  logic signed [VAL_BITS-1:0] ema_value;
  logic signed [SUM_BITS-1:0] window_sum;

  // Working registers.
  logic signed [VAL_BITS-1:0] x_val;
  logic                       win_end;
  logic signed [AW-1:0]       acc;
  logic signed [AW-1:0]       opd;
  logic [SUM_BITS-1:0]        quo;
  logic [DIV_BITS-1:0]        rem;
  logic                       neg;
  logic [VAL_BITS-1:0]        mag;
  logic signed [VAL_BITS-1:0] avg;
  logic signed [RES_BITS-1:0] res;

  // Shared adder.
  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic signed [AW-1:0] alu_y;
  logic                 alu_sub;

  logic signed [AW-1:0]       ema_shift;
  logic signed [VAL_BITS-1:0] ema_sat;
  logic signed [VAL_BITS-1:0] sum_add;
  logic [SUM_BITS-1:0]        sum_sat;
  logic [DIV_BITS-1:0]        div_eff;
  logic [VAL_BITS-1:0]        mag_lim;
  logic [VAL_BITS-1:0]        mag_clamp;
  logic                       gain_on;
  logic [AW-1:0]              prod_shift;
  logic [RES_BITS-1:0]        res_lim;
  logic [RES_BITS-1:0]        res_clamp;
  logic [CNT_BITS-1:0]        mul_pos;

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

  assign ema_shift = acc >>> ALPHA_BITS;
  assign ema_sat   = (ema_shift > VAL_MAX_W) ? VAL_MAX :
                     (ema_shift < VAL_MIN_W) ? VAL_MIN : ema_shift[VAL_BITS-1:0];

  assign sum_add = cfg.ema_enable ? ema_value : x_val;
  assign sum_sat = (alu_y[SUM_BITS] == alu_y[SUM_BITS-1]) ? alu_y[SUM_BITS-1:0] :
                   (alu_y[SUM_BITS] ? SUM_MIN : SUM_MAX);

  assign div_eff = (cfg.window_divisor == '0) ? DIV_BITS'(1) : cfg.window_divisor;

  // A negative average may reach one step further than a positive one.
  assign mag_lim   = neg ? VAL_MIN : VAL_MAX;
  assign mag_clamp = (quo > SUM_BITS'(mag_lim)) ? mag_lim : quo[VAL_BITS-1:0];

  assign gain_on    = (cfg.wire_type == WIRE_THREE) || (cfg.wire_type == WIRE_FOUR);
  assign prod_shift = gain_on ? (AW'(acc) >> SH_HIGH) : (AW'(acc) >> SH_LOW);
  assign res_lim    = neg ? RES_MIN : RES_MAX;
  assign res_clamp  = (prod_shift > AW'(res_lim)) ? res_lim : prod_shift[RES_BITS-1:0];

  // The product is built from the most significant reference bit down.
  assign mul_pos = MUL_LAST - ctl.cnt;

  assign sts.ema_direct = !cfg.ema_enable || (ema_value == '0);
  assign sts.win_end    = win_end;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctl.state)
      ST_PREP: begin
        alu_a   = AW'(x_val);
        alu_b   = AW'(ema_value);
        alu_sub = 1'b1;
      end
      ST_EMA: begin
        alu_a = acc;
        alu_b = ALPHA_Q16[ctl.cnt[ALPHA_IDX_BITS-1:0]] ? opd : '0;
      end
      ST_SUM: begin
        alu_a = AW'(window_sum);
        alu_b = AW'(sum_add);
      end
      ST_ABS: begin
        alu_b   = AW'(window_sum);
        alu_sub = window_sum[SUM_BITS-1];
      end
      ST_DIV: begin
        alu_a   = AW'({rem, quo[SUM_BITS-1]});
        alu_b   = AW'(div_eff);
        alu_sub = 1'b1;
      end
      ST_AVG: begin
        alu_b   = AW'(mag_clamp);
        alu_sub = neg;
      end
      ST_MUL: begin
        alu_a = acc <<< 1;
        alu_b = cfg.reference_mohm[mul_pos[REF_IDX_BITS-1:0]] ? AW'(mag) : '0;
      end
      ST_RES: begin
        alu_b   = AW'(res_clamp);
        alu_sub = neg;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Filter and window state, cleared by reset and when a window closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ema_value  <= '0;
      window_sum <= '0;
    end else begin
      case (ctl.state)
        ST_PREP: begin
          if (cfg.ema_enable && (ema_value == '0)) begin
            ema_value <= x_val;
          end
        end
        ST_EMA_WB: begin
          ema_value <= ema_sat;
        end
        ST_SUM: begin
          window_sum <= sum_sat;
        end
        ST_EMIT: begin
          if (ctl.emit) begin
            ema_value  <= '0;
            window_sum <= '0;
          end
        end
        default: begin
          ema_value <= ema_value;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_val   <= {sample, {FRACTION_BITS{1'b0}}};
      win_end <= window_end;
    end
    case (ctl.state)
      ST_PREP: begin
        // acc = ema * 65536 + 32768, opd = x - ema; then acc += alpha * opd.
        opd <= alu_y;
        acc <= (AW'(ema_value) <<< ALPHA_BITS) | AW'(EMA_ROUND);
      end
      ST_EMA: begin
        acc <= alu_y;
        opd <= opd <<< 1;
      end
      ST_ABS: begin
        neg <= window_sum[SUM_BITS-1];
        quo <= alu_y[SUM_BITS-1:0];
        rem <= '0;
      end
      ST_DIV: begin
        if (!alu_y[AW-1]) begin
          rem <= alu_y[DIV_BITS-1:0];
        end else begin
          rem <= {rem[DIV_BITS-2:0], quo[SUM_BITS-1]};
        end
        quo <= {quo[SUM_BITS-2:0], !alu_y[AW-1]};
      end
      ST_AVG: begin
        mag <= mag_clamp;
        avg <= alu_y[VAL_BITS-1:0];
        acc <= '0;
      end
      ST_MUL: begin
        acc <= alu_y;
      end
      ST_RES: begin
        res <= alu_y[RES_BITS-1:0];
      end
      ST_EMIT: begin
        if (ctl.emit) begin
          resistance_mohm <= res;
          average_q8      <= avg;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

### src/rtd_oversample_ema_resistance_top.sv
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    sample, window_end
// out       source     out_valid / out_stall  resistance_mohm, average_q8
// cfg       sink       cfg_write              cfg_index, cfg_data
//
// A word is taken only while the block is idle, so one word is in work at a time.
// A plain sample passes through preparation and the window sum when the filter is
// bypassed or loaded, and first through the 16 shift-and-add steps of alpha on the
// shared adder and a write-back of the filter value when the filter runs.
// A word marked window end then goes on to the magnitude, 40 restoring division
// steps, the average, 24 multiply steps against the reference and the resistance,
// all on the same adder.
// Reset is synchronous and returns the registers to their defaults and clears the
// filter value and the window sum. The result word sits in an output register;
// while it is stalled the block still takes new words and only waits when the
// next result is ready before the previous one has left.
module rtd_oversample_ema_resistance_top
  import rtdos_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [SAMPLE_BITS-1:0]               sample,
  input  logic                                        window_end,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic signed [RES_BITS-1:0]                  resistance_mohm,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] average_q8,
  input  logic                                        cfg_write,
  input  logic [CFG_IDX_BITS-1:0]                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                    cfg_data
);

  cfg_t cfg;
  ctl_t ctl;
  sts_t sts;
  logic load;
  logic out_free;

  // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_divisor <= DIVISOR_RST;
      cfg.reference_mohm <= REF_RST;
      cfg.wire_type      <= WIRE_RST;
      cfg.ema_enable     <= EMA_EN_RST;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_DIVISOR: cfg.window_divisor <= cfg_data[DIV_BITS-1:0];
        CFG_REFERENCE_MOHM: cfg.reference_mohm <= cfg_data[REF_BITS-1:0];
        CFG_WIRE_TYPE:      cfg.wire_type      <= cfg_data[WIRE_BITS-1:0];
        CFG_EMA_ENABLE:     cfg.ema_enable     <= cfg_data[0];
        default:            cfg.ema_enable     <= cfg.ema_enable;
      endcase
    end
  end

  assign load     = in_valid && !in_stall;
  // The output register can take a new word when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  rtdos_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  rtdos_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .cfg             (cfg),
    .load            (load),
    .sample          (sample),
    .window_end      (window_end),
    .sts             (sts),
    .resistance_mohm (resistance_mohm),
    .average_q8      (average_q8)
  );

endmodule

### src/rtdos_checker.sv
module rtdos_checker
  import rtdos_pkg::*;
#(
  parameter int VAL_BITS = 24
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [RES_BITS-1:0]        resistance_mohm,
  input logic [VAL_BITS-1:0]        average_q8
);

  // An accepted word always makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(resistance_mohm) &&
      $stable(average_q8))
    else $error("stalled result word changed or vanished");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle and empty after reset");

  // A result is only produced at the end of work on a word.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

  a_sign_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && resistance_mohm[RES_BITS-1] |-> average_q8[VAL_BITS-1])
    else $error("negative resistance from a non-negative average");

endmodule

bind rtd_oversample_ema_resistance_top rtdos_checker #(
  .VAL_BITS (SAMPLE_BITS + FRACTION_BITS)
) u_checker (.*);
